@@ rtl/uyvy_to_i420_decimating_resizer_assert.svh @@
// Assertion macros for the resizer RTL, used by the merge stage.
`ifndef UYVY_TO_I420_DECIMATING_RESIZER_ASSERT_SVH
`define UYVY_TO_I420_DECIMATING_RESIZER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define U2I_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define U2I_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/u2i_rsz_pkg.sv @@
// Types, codes and constants shared by the UYVY to I420 resizer.
package u2i_rsz_pkg;

  localparam int CFG_W          = 12;
  localparam int SAMPLE_W       = 8;
  localparam int LUMA_IDX_W     = 22;
  localparam int CHROMA_IDX_W   = 20;
  localparam int SLOT_N         = 4;
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;
  localparam logic [CFG_W-1:0] RESET_WIDTH  = 12'd1280;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 12'd720;

  // Slot positions, in output order.
  localparam int SLOT_Y0 = 0;
  localparam int SLOT_Y1 = 1;
  localparam int SLOT_U  = 2;
  localparam int SLOT_V  = 3;

  typedef enum logic [1:0] {
    SCALE_FULL       = 2'd0,
    SCALE_TWO_THIRDS = 2'd1,
    SCALE_HALF       = 2'd2,
    SCALE_THIRD      = 2'd3
  } scale_mode_t;

  typedef enum logic [1:0] {
    REG_SCALE_MODE   = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PLANE_Y = 2'd0,
    PLANE_U = 2'd1,
    PLANE_V = 2'd2
  } plane_t;

  typedef enum logic {
    LANE_LUMA   = 1'b0,
    LANE_CHROMA = 1'b1
  } lane_kind_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] u_byte;
    logic [SAMPLE_W-1:0] luma_first;
    logic [SAMPLE_W-1:0] v_byte;
    logic [SAMPLE_W-1:0] luma_second;
  } in_beat_t;

  typedef struct packed {
    plane_t                plane_sel;
    logic [LUMA_IDX_W-1:0] plane_index;
    logic [SAMPLE_W-1:0]   sample_value;
    logic                  run_last;
    logic                  frame_end;
  } out_beat_t;

  // Position phases that one lane needs to decide keep.
  typedef struct packed {
    scale_mode_t mode;
    logic [1:0]  col_m3;
    logic        col_odd;
    logic [2:0]  row_m6;
    logic [1:0]  row_m4;
  } lane_ctl_t;

  typedef struct packed {
    plane_t                plane;
    logic [LUMA_IDX_W-1:0] index;
    logic [SAMPLE_W-1:0]   value;
  } sample_t;

  typedef struct packed {
    logic [SLOT_N-1:0]      keep;
    logic                   frame_end;
    sample_t [SLOT_N-1:0]   samp;
  } slot_t;

endpackage

@@ rtl/uyvy_to_i420_decimating_resizer.sv @@
// Top level: UYVY pair input, position tracking, keep lanes and sample output.
// First sample of an accepted pair passes the slot, then the output register.
// Kept samples leave in turn through the single output register, and the next
// pair loads as the last one moves out; full size keeps 4 samples on even rows
// and 2 on odd rows. A pair with nothing kept needs a free slot and yields no beat.
// Reset (rst, synchronous): position, plane counters, slot and output cleared;
// registers return to full size, 1280 by 720.
module uyvy_to_i420_decimating_resizer
  import u2i_rsz_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_beat_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_beat_t        out_data
);

  localparam int PW  = $clog2(MAX_WIDTH / 2);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WWA = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
  localparam int HWA = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;

  scale_mode_t      scale_mode;
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;

  logic [PW-1:0]           pair_column;
  logic [1:0]              pair_m3;
  logic [RW-1:0]           row_count;
  logic [2:0]              row_m6;
  logic [LUMA_IDX_W-1:0]   luma_count;
  logic [CHROMA_IDX_W-1:0] chroma_count;

  logic [WWA-1:0] w_eff;
  logic [WWA-1:0] pairs;
  logic [HWA-1:0] h_eff;
  logic           row_end;
  logic           frame_done;
  logic           accept;

  lane_ctl_t  ctl_y0, ctl_y1, ctl_c;
  logic [1:0] x0_m3, x1_m3;
  logic       keep_y0, keep_y1, keep_c;
  slot_t      slot_in;

  // Take configuration writes; writes beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_mode   <= SCALE_FULL;
      frame_width  <= RESET_WIDTH;
      frame_height <= RESET_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCALE_MODE:   scale_mode   <= scale_mode_t'(cfg_data[1:0]);
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the frame size and find row and frame ends.
  always_comb begin
    w_eff = (WWA'(frame_width) > WWA'(MAX_WIDTH)) ? WWA'(MAX_WIDTH) : WWA'(frame_width);
    h_eff = (HWA'(frame_height) > HWA'(MAX_HEIGHT)) ? HWA'(MAX_HEIGHT)
                                                    : HWA'(frame_height);
    pairs = w_eff >> 1;
    if (pairs == '0) pairs = WWA'(1);
    if (h_eff == '0) h_eff = HWA'(1);
    row_end    = (WWA'(pair_column) + WWA'(1)) >= pairs;
    frame_done = row_end && ((HWA'(row_count) + HWA'(1)) >= h_eff);
  end

  // Column phases of the two pixels: x0 = 2*pair, x1 = x0 + 1.
  always_comb begin
    unique case (pair_m3)
      2'd0:    x0_m3 = 2'd0;
      2'd1:    x0_m3 = 2'd2;
      2'd2:    x0_m3 = 2'd1;
      default: x0_m3 = 2'd0;
    endcase
    x1_m3 = (x0_m3 == 2'd2) ? 2'd0 : 2'(x0_m3 + 2'd1);
  end

  always_comb begin
    ctl_y0 = '{mode: scale_mode, col_m3: x0_m3, col_odd: 1'b0,
               row_m6: row_m6, row_m4: row_count[1:0]};
    ctl_y1 = '{mode: scale_mode, col_m3: x1_m3, col_odd: 1'b1,
               row_m6: row_m6, row_m4: row_count[1:0]};
    ctl_c  = '{mode: scale_mode, col_m3: pair_m3, col_odd: pair_column[0],
               row_m6: row_m6, row_m4: row_count[1:0]};
  end

  u2i_rsz_lane u_lane_y0 (.kind(LANE_LUMA),   .ctl(ctl_y0), .keep(keep_y0));
  u2i_rsz_lane u_lane_y1 (.kind(LANE_LUMA),   .ctl(ctl_y1), .keep(keep_y1));
  u2i_rsz_lane u_lane_c  (.kind(LANE_CHROMA), .ctl(ctl_c),  .keep(keep_c));

  // Build the slot for this pair, indices taken from the plane counters.
  always_comb begin
    slot_in.keep      = {keep_c, keep_c, keep_y1, keep_y0};
    slot_in.frame_end = frame_done;
    slot_in.samp[SLOT_Y0] = '{plane: PLANE_Y, index: luma_count,
                              value: in_data.luma_first};
    slot_in.samp[SLOT_Y1] = '{plane: PLANE_Y,
                              index: luma_count + LUMA_IDX_W'(keep_y0),
                              value: in_data.luma_second};
    slot_in.samp[SLOT_U]  = '{plane: PLANE_U, index: LUMA_IDX_W'(chroma_count),
                              value: in_data.u_byte};
    slot_in.samp[SLOT_V]  = '{plane: PLANE_V, index: LUMA_IDX_W'(chroma_count),
                              value: in_data.v_byte};
  end

  assign accept = in_valid && in_ready;

  // Advance position and plane counters per accepted beat.
  // U and V always advance together, so one chroma counter serves both.
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_column  <= '0;
      pair_m3      <= 2'd0;
      row_count    <= '0;
      row_m6       <= 3'd0;
      luma_count   <= '0;
      chroma_count <= '0;
    end else if (accept) begin
      if (frame_done) begin
        pair_column  <= '0;
        pair_m3      <= 2'd0;
        row_count    <= '0;
        row_m6       <= 3'd0;
        luma_count   <= '0;
        chroma_count <= '0;
      end else begin
        luma_count   <= luma_count + LUMA_IDX_W'(keep_y0) + LUMA_IDX_W'(keep_y1);
        chroma_count <= chroma_count + CHROMA_IDX_W'(keep_c);
        if (row_end) begin
          pair_column <= '0;
          pair_m3     <= 2'd0;
          row_count   <= row_count + RW'(1);
          row_m6      <= (row_m6 == 3'd5) ? 3'd0 : 3'(row_m6 + 3'd1);
        end else begin
          pair_column <= pair_column + PW'(1);
          pair_m3     <= (pair_m3 == 2'd2) ? 2'd0 : 2'(pair_m3 + 2'd1);
        end
      end
    end
  end

  u2i_rsz_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && (slot_in.keep != '0)),
    .load_slot (slot_in),
    .slot_free (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ rtl/u2i_rsz_lane.sv @@
// Keep decision for one sample lane (luma pixel or chroma pair).
module u2i_rsz_lane
  import u2i_rsz_pkg::*;
(
  input  lane_kind_t kind,
  input  lane_ctl_t  ctl,
  output logic       keep
);

  logic [1:0] row_m3;

  // Fold row mod 6 down to row mod 3.
  assign row_m3 = (ctl.row_m6 >= 3'd3) ? 2'(ctl.row_m6 - 3'd3) : ctl.row_m6[1:0];

  // Apply the decimation pattern of the selected mode.
  always_comb begin
    keep = 1'b0;
    unique case (kind)
      LANE_LUMA: begin
        unique case (ctl.mode)
          SCALE_FULL:       keep = 1'b1;
          SCALE_TWO_THIRDS: keep = (ctl.col_m3 != 2'd2) && (row_m3 != 2'd2);
          SCALE_HALF:       keep = !ctl.col_odd && !ctl.row_m6[0];
          SCALE_THIRD:      keep = (ctl.col_m3 == 2'd0) && (row_m3 == 2'd0);
          default:          keep = 1'b0;
        endcase
      end
      LANE_CHROMA: begin
        unique case (ctl.mode)
          SCALE_FULL:       keep = !ctl.row_m6[0];
          SCALE_TWO_THIRDS: keep = (ctl.col_m3 != 2'd2) &&
                                   ((ctl.row_m6 == 3'd0) || (ctl.row_m6 == 3'd3));
          SCALE_HALF:       keep = !ctl.col_odd && (ctl.row_m4 == 2'd0);
          SCALE_THIRD:      keep = (ctl.col_m3 == 2'd0) && (ctl.row_m6 == 3'd0);
          default:          keep = 1'b0;
        endcase
      end
      default: keep = 1'b0;
    endcase
  end

endmodule

@@ rtl/u2i_rsz_merge.sv @@
// Merge stage: holds one pair's kept samples and serializes them to the output.
module u2i_rsz_merge
  import u2i_rsz_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  slot_t     load_slot,
  output logic      slot_free,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  `include "uyvy_to_i420_decimating_resizer_assert.svh"

  logic [SLOT_N-1:0] slot_keep;
  logic              slot_frame_end;
  sample_t [SLOT_N-1:0] slot_samp;

  logic              adv;
  logic [1:0]        pick_idx;
  logic [SLOT_N-1:0] pick_mask;
  logic [SLOT_N-1:0] rest;

  // Advance the output register when it is empty or being taken.
  assign adv = !out_valid || out_ready;

  // Pick the first kept sample still in the slot.
  always_comb begin
    pick_idx = 2'(SLOT_Y0);
    priority if (slot_keep[SLOT_Y0]) pick_idx = 2'(SLOT_Y0);
    else if (slot_keep[SLOT_Y1])     pick_idx = 2'(SLOT_Y1);
    else if (slot_keep[SLOT_U])      pick_idx = 2'(SLOT_U);
    else                             pick_idx = 2'(SLOT_V);
    pick_mask = SLOT_N'(1) << pick_idx;
  end

  assign rest      = slot_keep & ~pick_mask;
  assign slot_free = (slot_keep == '0) || (adv && (rest == '0));

  // Hold or refill the slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_keep <= '0;
    end else if (load) begin
      slot_keep <= load_slot.keep;
    end else if (adv) begin
      slot_keep <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_frame_end <= load_slot.frame_end;
      slot_samp      <= load_slot.samp;
    end
  end

  // Move the picked sample into the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= (slot_keep != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv && (slot_keep != '0)) begin
      out_data.plane_sel    <= slot_samp[pick_idx].plane;
      out_data.plane_index  <= slot_samp[pick_idx].index;
      out_data.sample_value <= slot_samp[pick_idx].value;
      out_data.run_last     <= (rest == '0);
      out_data.frame_end    <= slot_frame_end;
    end
  end

  `U2I_ASSERT_NEXT(a_v_follows_u, out_valid && out_ready && (out_data.plane_sel == PLANE_U), out_valid && (out_data.plane_sel == PLANE_V), "V beat must follow U beat")
  `U2I_ASSERT_NOW(a_u_not_last, out_valid && (out_data.plane_sel == PLANE_U), !out_data.run_last, "U beat marked last")
  `U2I_ASSERT_NEXT(a_run_continues, out_valid && out_ready && !out_data.run_last, out_valid, "run broken before last beat")

endmodule

@@ tb/uyvy_to_i420_decimating_resizer_test.sv @@
// Self-checking testbench for the UYVY to I420 decimating resizer.
`timescale 1ns / 1ps

module uyvy_to_i420_decimating_resizer_test;
  import u2i_rsz_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES = 20;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_index = REG_SCALE_MODE;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_beat_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_beat_t        out_data;

  // Register mirror and position tracking for the sample predictor
  scale_mode_t      cur_mode = SCALE_FULL;
  logic [CFG_W-1:0] cur_w = RESET_WIDTH;
  logic [CFG_W-1:0] cur_h = RESET_HEIGHT;
  logic [9:0]       pos_pair = '0;
  logic [10:0]      pos_row = '0;
  logic [21:0]      cnt_y = '0;
  logic [19:0]      cnt_u = '0;
  logic [19:0]      cnt_v = '0;

  in_beat_t  uyvy_pairs[$];
  out_beat_t kept_samples[$];

  bit in_acc, out_acc;
  bit send_calm, recv_calm;
  int send_wait, recv_wait, hold_left;
  int hold_asked, hold_taken;
  int quiet, err_count, beat_no;

  uyvy_to_i420_decimating_resizer uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit luma_keep(scale_mode_t m, int unsigned x, int unsigned y);
    case (m)
      SCALE_TWO_THIRDS: return (x % 3 != 2) && (y % 3 != 2);
      SCALE_HALF:       return (x % 2 == 0) && (y % 2 == 0);
      SCALE_THIRD:      return (x % 3 == 0) && (y % 3 == 0);
      default:          return 1'b1;
    endcase
  endfunction

  function automatic bit chroma_keep(scale_mode_t m, int unsigned p, int unsigned y);
    case (m)
      SCALE_TWO_THIRDS: return (p % 3 != 2) && (y % 6 == 0 || y % 6 == 3);
      SCALE_HALF:       return (p % 2 == 0) && (y % 4 == 0);
      SCALE_THIRD:      return (p % 3 == 0) && (y % 6 == 0);
      default:          return y % 2 == 0;
    endcase
  endfunction

  function automatic out_beat_t make_sample(plane_t pl, logic [21:0] idx, logic [7:0] val);
    out_beat_t s;
    s = '0;
    s.plane_sel = pl;
    s.plane_index = idx;
    s.sample_value = val;
    return s;
  endfunction

  // Work out the samples kept from one pixel pair and advance the position
  task automatic decimate_pair(in_beat_t b);
    int unsigned w, h, pairs, x0, pc, row;
    bit row_end, last_pair;
    out_beat_t got[4];
    int n;
    w = (cur_w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : cur_w;
    h = (cur_h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : cur_h;
    pairs = w >> 1;
    if (pairs == 0) pairs = 1;
    if (h == 0) h = 1;
    pc = pos_pair;
    row = pos_row;
    x0 = pc * 2;
    row_end = pc + 1 >= pairs;
    last_pair = row_end && (row + 1 >= h);
    n = 0;
    if (luma_keep(cur_mode, x0, row)) begin
      got[n] = make_sample(PLANE_Y, cnt_y, b.luma_first);
      cnt_y++;
      n++;
    end
    if (luma_keep(cur_mode, x0 + 1, row)) begin
      got[n] = make_sample(PLANE_Y, cnt_y, b.luma_second);
      cnt_y++;
      n++;
    end
    if (chroma_keep(cur_mode, pc, row)) begin
      got[n] = make_sample(PLANE_U, {2'b00, cnt_u}, b.u_byte);
      cnt_u++;
      n++;
      got[n] = make_sample(PLANE_V, {2'b00, cnt_v}, b.v_byte);
      cnt_v++;
      n++;
    end
    for (int k = 0; k < n; k++) begin
      got[k].frame_end = last_pair;
      got[k].run_last = (k == n - 1);
      kept_samples.push_back(got[k]);
    end
    // Wrap the position at row and frame ends
    if (last_pair) begin
      pos_pair = '0;
      pos_row = '0;
      cnt_y = '0;
      cnt_u = '0;
      cnt_v = '0;
    end else if (row_end) begin
      pos_pair = '0;
      pos_row++;
    end else begin
      pos_pair++;
    end
  endtask

  task automatic report(input string msg);
    $display("MISMATCH beat %0d: %s", beat_no, msg);
    err_count++;
  endtask

  task automatic check_sample(out_beat_t got);
    out_beat_t want;
    if (kept_samples.size() == 0) begin
      report($sformatf("unexpected sample plane %0d index %0d value %0h",
                       got.plane_sel, got.plane_index, got.sample_value));
    end else begin
      want = kept_samples.pop_front();
      if (got.plane_sel !== want.plane_sel)
        report($sformatf("plane_sel %0d, want %0d", got.plane_sel, want.plane_sel));
      if (got.plane_index !== want.plane_index)
        report($sformatf("plane_index %0d, want %0d", got.plane_index, want.plane_index));
      if (got.sample_value !== want.sample_value)
        report($sformatf("sample_value %0h, want %0h", got.sample_value,
                         want.sample_value));
      if (got.run_last !== want.run_last)
        report($sformatf("run_last %0b, want %0b", got.run_last, want.run_last));
      if (got.frame_end !== want.frame_end)
        report($sformatf("frame_end %0b, want %0b", got.frame_end, want.frame_end));
    end
    beat_no++;
  endtask

  // Sample both handshakes, predict, check and watch for a hang
  always @(posedge clk) begin
    in_acc = 1'b0;
    out_acc = 1'b0;
    if (!rst) begin
      in_acc = in_valid && in_ready;
      out_acc = out_valid && out_ready;
      if (in_acc) decimate_pair(in_data);
      if (out_acc) check_sample(out_data);
      if (in_acc || out_acc || cfg_we) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("uyvy_to_i420_decimating_resizer_test NOT OK");
        $finish;
      end
    end
  end

  // Drive pixel pairs: hold each beat until taken, then idle for its drawn gap
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_acc) begin
      // hold the current beat
    end else if (send_wait > 0) begin
      in_valid <= 1'b0;
      send_wait--;
    end else if (uyvy_pairs.size() != 0) begin
      in_valid <= 1'b1;
      in_data <= uyvy_pairs.pop_front();
      send_wait = send_calm ? 0 : $urandom_range(0, 8);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Take samples: stall after each beat, and hold off for a long stretch on request
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_acc && recv_wait == 0) recv_wait = recv_calm ? 0 : $urandom_range(0, 8);
      if (hold_taken != hold_asked) begin
        hold_left = HOLD_CYCLES;
        hold_taken = hold_asked;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (recv_wait > 0) begin
        out_ready <= 1'b0;
        recv_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Wait until every pair is in and every sample is out, then let the pipe settle
  task automatic wait_idle(int settle);
    while (uyvy_pairs.size() != 0 || in_valid || kept_samples.size() != 0)
      @(posedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_SCALE_MODE:   cur_mode = scale_mode_t'(val[1:0]);
      REG_FRAME_WIDTH:  cur_w = val;
      REG_FRAME_HEIGHT: cur_h = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(scale_mode_t m, logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    wait_idle(8);
    write_reg(REG_SCALE_MODE, {10'd0, m});
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  task automatic push_random(int n);
    repeat (n) uyvy_pairs.push_back(in_beat_t'($urandom));
  endtask

  initial begin
    scale_mode_t m;
    logic [CFG_W-1:0] w, h;
    int total, n, phase;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Full size, two by two pairs: field extremes and a frame end
    set_config(SCALE_FULL, 12'd4, 12'd2);
    uyvy_pairs.push_back('{8'h00, 8'h00, 8'h00, 8'h00});
    uyvy_pairs.push_back('{8'hFF, 8'hFF, 8'hFF, 8'hFF});
    uyvy_pairs.push_back('{8'hAA, 8'h55, 8'hAA, 8'h55});
    uyvy_pairs.push_back('{8'h55, 8'hAA, 8'h55, 8'hAA});
    // One third: second row keeps nothing, so the final pair gives no sample
    set_config(SCALE_THIRD, 12'd4, 12'd2);
    push_random(4);
    // Two thirds on an odd width, one row
    set_config(SCALE_TWO_THIRDS, 12'd7, 12'd1);
    push_random(3);
    // Zero width and height: every pair is a whole frame
    set_config(SCALE_HALF, 12'd0, 12'd0);
    push_random(2);
    // Oversize frame, left mid row
    set_config(SCALE_FULL, 12'd4095, 12'd4095);
    push_random(3);
    // Shrink mid frame: the column is already past the row end
    set_config(SCALE_TWO_THIRDS, 12'd4, 12'd1);
    push_random(3);

    // Random phases of small frames with random content
    total = 0;
    phase = 0;
    while (total < 80) begin
      m = scale_mode_t'(2'($urandom_range(0, 3)));
      case ($urandom_range(0, 9))
        0: w = CFG_W'($urandom_range(0, 3));
        1: w = ($urandom_range(0, 1) != 0) ? 12'd4095 : 12'd2046;
        default: w = CFG_W'(2 * $urandom_range(1, 8) +
                            (($urandom_range(0, 4) == 0) ? 1 : 0));
      endcase
      case ($urandom_range(0, 9))
        0: h = CFG_W'($urandom_range(0, 1));
        1: h = 12'd4095;
        default: h = CFG_W'($urandom_range(2, 9));
      endcase
      n = $urandom_range(4, 24);
      set_config(m, w, h);
      send_calm = ($urandom_range(0, 3) == 0);
      recv_calm = ($urandom_range(0, 3) == 0);
      // Stall the receiver long while the sender keeps pushing
      if (phase == 2) begin
        send_calm = 1'b1;
        n = 24;
        hold_asked++;
      end
      push_random(n);
      total += n;
      phase++;
    end

    wait_idle(DRAIN_CYCLES);
    if (kept_samples.size() != 0)
      report($sformatf("%0d expected samples never arrived", kept_samples.size()));
    if (err_count == 0) begin
      $display("uyvy_to_i420_decimating_resizer_test OK");
    end else begin
      $display("uyvy_to_i420_decimating_resizer_test NOT OK");
    end
    $finish;
  end

endmodule
